// ===== design/soa_pkg.sv =====
// Shared types and constants for the slot owner allocator.
`timescale 1ns / 1ps
`default_nettype none

package soa_pkg;

	localparam int SLOTS_DEFAULT       = 64;
	localparam int ENTITY_BITS_DEFAULT = 16;

	// fixed widths of the stream fields
	localparam int SLOT_W   = 6;
	localparam int ENTITY_W = 16;
	localparam int COUNT_W  = 7;
	localparam int IN_W     = 32;
	localparam int OUT_W    = 32;

	typedef enum logic [2:0] {
		ACT_ADD    = 3'd0,
		ACT_DELETE = 3'd1,
		ACT_READ   = 3'd2,
		ACT_SET    = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_SLOT_FREE = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ===== design/slot_owner_allocator_top.sv =====
// Top level of the first-fit slot owner allocator.
//
// Usage notes:
// - Requests arrive on the s_axis channel, one transaction per operation:
//   add, delete, read owner, set owner or clear all. Every request gives
//   exactly one response transaction on m_axis.
// - Owners live in a single-port synchronous RAM; occupancy bits and the
//   used count sit in flops. A free slot always reads back as the free
//   marker because the occupancy bit gates the RAM data, so neither reset
//   nor clear-all has to sweep the RAM.
// - Response path: the request and the owner RAM read-out are registered at
//   acceptance; the update stage then loads the response into the output
//   register, raising m_axis_tvalid, once that register is free or drained.
// - The request stage is held busy while the owner RAM read completes and the
//   update is written back, so no new request is accepted until the last one
//   completes, and a read never meets a pending write to the same slot.
// - Backpressure: a response waiting in the output register does not block
//   acceptance of the next request; only a second response that finds the
//   register still full stalls the update stage, which then holds.
// - Reset (arst_n low) frees every slot and zeroes the used count at once.
`timescale 1ns / 1ps
`default_nettype none

module slot_owner_allocator_top #(
	parameter int SLOTS       = soa_pkg::SLOTS_DEFAULT,
	parameter int ENTITY_BITS = soa_pkg::ENTITY_BITS_DEFAULT
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// request channel
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	// [2:0] action, [8:3] slot, [24:9] entity, [31:25] zero
	input  wire logic [soa_pkg::IN_W-1:0] s_axis_tdata,
	// response channel
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	// [5:0] slot_index, [21:6] owner_entity, [22] occupied,
	// [24:23] status, [31:25] used_count
	output logic [soa_pkg::OUT_W-1:0]     m_axis_tdata
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int EW = ENTITY_BITS;

	localparam logic [EW-1:0] FREE_MARK = {EW{1'b1}};

	// ---------------------------------------------------------------
	// request unpacking
	// ---------------------------------------------------------------
	soa_pkg::action_t                 in_act;
	logic [soa_pkg::SLOT_W-1:0]       in_slot;
	logic [soa_pkg::ENTITY_W-1:0]     in_entity;
	logic [31:0]                      in_slot_ext;
	logic [31:0]                      in_ent_ext;
	logic [EW-1:0]                    in_ent;
	logic [AW-1:0]                    in_addr;
	logic                             in_valid_slot;
	logic                             in_acc;

	assign in_act      = soa_pkg::action_t'(s_axis_tdata[2:0]);
	assign in_slot     = s_axis_tdata[8:3];
	assign in_entity   = s_axis_tdata[24:9];
	assign in_slot_ext = {26'd0, in_slot};
	assign in_ent_ext  = {16'd0, in_entity};
	assign in_ent      = in_ent_ext[EW-1:0];
	assign in_addr     = in_slot_ext[AW-1:0];
	assign in_valid_slot = (in_slot_ext < 32'(SLOTS));

	// ---------------------------------------------------------------
	// state: occupancy, count, busy flag, stage-1 request
	// ---------------------------------------------------------------
	logic [SLOTS-1:0]                 occ_q, occ_d;
	logic [CW-1:0]                    count_q, count_d;
	logic                             busy_q;

	soa_pkg::action_t                 act_s1;
	logic [soa_pkg::SLOT_W-1:0]       slot_s1;
	logic [EW-1:0]                    ent_s1;
	logic                             hit_s1;   // slot in range and owned
	logic                             full_s1;
	logic [AW-1:0]                    addr_s1;
	logic [AW-1:0]                    free_s1;
	logic [EW-1:0]                    rdata_q;

	logic                             out_valid_q;
	logic [soa_pkg::OUT_W-1:0]        out_data_q;

	logic                             ff_found;
	logic [AW-1:0]                    ff_idx;

	logic                             done;

	assign s_axis_tready = !busy_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign done          = busy_q && (!out_valid_q || m_axis_tready);

	soa_first_free #(
		.SLOTS (SLOTS),
		.AW    (AW)
	) u_first_free (
		.occ   (occ_q),
		.found (ff_found),
		.idx   (ff_idx)
	);

	// ---------------------------------------------------------------
	// owner RAM: read on accept, write back on completion
	// ---------------------------------------------------------------
	logic [EW-1:0]                    owner_mem [SLOTS];
	logic                             mem_we;
	logic [AW-1:0]                    mem_waddr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			owner_mem[mem_waddr] <= ent_s1;
		end
		if (in_acc) begin
			rdata_q <= owner_mem[in_addr];
		end
	end

	// stage-1 payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_s1  <= in_act;
			slot_s1 <= in_slot;
			ent_s1  <= in_ent;
			hit_s1  <= in_valid_slot && occ_q[in_addr];
			full_s1 <= !ff_found;
			addr_s1 <= in_addr;
			free_s1 <= ff_idx;
		end
	end

	// ---------------------------------------------------------------
	// update and response
	// ---------------------------------------------------------------
	logic [AW-1:0]                    res_idx;
	logic [EW-1:0]                    res_owner;
	logic                             res_occ;
	soa_pkg::status_t                 res_status;
	logic [31:0]                      idx_ext, own_ext, cnt_ext;
	logic [soa_pkg::SLOT_W-1:0]       res_slot;

	always_comb begin
		occ_d      = occ_q;
		count_d    = count_q;
		mem_we     = 1'b0;
		mem_waddr  = addr_s1;
		res_idx    = addr_s1;
		res_slot   = slot_s1;
		res_owner  = FREE_MARK;
		res_occ    = 1'b0;
		res_status = soa_pkg::ST_OK;
		idx_ext    = '0;
		own_ext    = '0;
		cnt_ext    = '0;

		case (act_s1)
			soa_pkg::ACT_ADD: begin
				if (full_s1) begin
					res_status = soa_pkg::ST_FULL;
					res_slot   = '0;
				end else begin
					occ_d[free_s1] = 1'b1;
					count_d        = count_q + CW'(1);
					mem_we         = 1'b1;
					mem_waddr      = free_s1;
					res_owner      = ent_s1;
					res_occ        = 1'b1;
					res_idx        = free_s1;
					idx_ext[AW-1:0] = free_s1;
					res_slot       = idx_ext[soa_pkg::SLOT_W-1:0];
				end
			end
			soa_pkg::ACT_DELETE: begin
				if (hit_s1) begin
					occ_d[addr_s1] = 1'b0;
					count_d        = count_q - CW'(1);
				end else begin
					res_status = soa_pkg::ST_SLOT_FREE;
				end
			end
			soa_pkg::ACT_SET: begin
				if (hit_s1) begin
					mem_we    = 1'b1;
					res_owner = ent_s1;
					res_occ   = 1'b1;
				end else begin
					res_status = soa_pkg::ST_SLOT_FREE;
				end
			end
			soa_pkg::ACT_CLEAR: begin
				occ_d   = '0;
				count_d = '0;
			end
			default: begin
				// read owner and unused codes; free slots read the free marker
				if (hit_s1) begin
					res_owner = rdata_q;
					res_occ   = 1'b1;
				end
			end
		endcase

		if (!done) begin
			mem_we = 1'b0;
		end

		own_ext[EW-1:0] = res_owner;
		cnt_ext[CW-1:0] = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			count_q     <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				occ_q       <= occ_d;
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (done) begin
			out_data_q <= {cnt_ext[soa_pkg::COUNT_W-1:0], res_status, res_occ,
				own_ext[soa_pkg::ENTITY_W-1:0], res_slot};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	logic [AW-1:0] res_idx_unused_chk;
	assign res_idx_unused_chk = res_idx;

	a_count_matches_occ: assert property (@(posedge clk) disable iff (!arst_n)
		32'($countones(occ_q)) == 32'(count_q))
		else $error("used count differs from occupancy population");

	a_no_accept_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_axis_tready)
		else $error("request accepted while update stage busy");

	a_add_claims_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (act_s1 == soa_pkg::ACT_ADD) && !full_s1
		|=> occ_q[$past(res_idx_unused_chk)] && (count_q == $past(count_q) + CW'(1)))
		else $error("add did not claim the free slot");

	a_done_gives_response: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> m_axis_tvalid)
		else $error("completed request produced no response");

endmodule

`default_nettype wire

// ===== design/soa_first_free.sv =====
// Priority encoder: lowest free slot in the occupancy vector.
`timescale 1ns / 1ps
`default_nettype none

module soa_first_free #(
	parameter int SLOTS = soa_pkg::SLOTS_DEFAULT,
	parameter int AW    = 6
) (
	input  wire logic [SLOTS-1:0] occ,
	output logic                  found,
	output logic [AW-1:0]         idx
);

	always_comb begin
		idx   = '0;
		found = 1'b0;
		// scan downwards so the lowest free slot wins
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!occ[i]) begin
				idx   = AW'(i);
				found = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the first-fit slot owner allocator.
`timescale 1ns / 1ps

module testbench;

	// spare action codes behave as read owner
	localparam logic [2:0]  ACT_SPARE_5 = 3'd5;
	localparam logic [2:0]  ACT_SPARE_6 = 3'd6;
	localparam logic [2:0]  ACT_SPARE_7 = 3'd7;
	localparam logic [15:0] FREE_OWNER  = 16'hFFFF;
	localparam int          TABLE_SLOTS = 64;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          PRINT_CAP   = 40;

	typedef struct packed {
		logic [5:0]        slot_index;
		logic [15:0]       owner_entity;
		logic              occupied;
		soa_pkg::status_t  status;
		logic [6:0]        used_count;
	} alloc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	// testbench copy of the allocator state
	logic [15:0] owner_copy [TABLE_SLOTS];
	logic [63:0] held_slots = '0;
	int          used_slots = 0;

	alloc_result_t pending_results[$];
	int            mismatches = 0;
	int            cycles = 0;
	bit            calm = 1'b0;	// no idling on either side while set

	slot_owner_allocator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < TABLE_SLOTS; i++)
			owner_copy[i] = FREE_OWNER;
	end

	// works out the response to one request and updates the state copy
	function automatic alloc_result_t predict_alloc(input logic [2:0] act,
			input logic [5:0] slot, input logic [15:0] ent);
		alloc_result_t r;
		int first_free;
		r.slot_index   = slot;
		r.owner_entity = FREE_OWNER;
		r.occupied     = 1'b0;
		r.status       = soa_pkg::ST_OK;
		case (act)
			soa_pkg::ACT_ADD: begin
				first_free = -1;
				for (int i = 0; i < TABLE_SLOTS; i++)
					if (!held_slots[i] && first_free < 0)
						first_free = i;
				if (first_free < 0) begin
					r.slot_index = '0;
					r.status     = soa_pkg::ST_FULL;
				end else begin
					held_slots[first_free] = 1'b1;
					owner_copy[first_free] = ent;
					used_slots++;
					r.slot_index   = 6'(first_free);
					r.owner_entity = ent;
					r.occupied     = 1'b1;
				end
			end
			soa_pkg::ACT_DELETE: begin
				if (held_slots[slot]) begin
					held_slots[slot] = 1'b0;
					owner_copy[slot] = FREE_OWNER;
					used_slots--;
				end else
					r.status = soa_pkg::ST_SLOT_FREE;
			end
			soa_pkg::ACT_SET: begin
				if (held_slots[slot]) begin
					owner_copy[slot] = ent;
					r.owner_entity   = ent;
					r.occupied       = 1'b1;
				end else begin
					r.owner_entity = owner_copy[slot];
					r.status       = soa_pkg::ST_SLOT_FREE;
				end
			end
			soa_pkg::ACT_CLEAR: begin
				held_slots = '0;
				for (int i = 0; i < TABLE_SLOTS; i++)
					owner_copy[i] = FREE_OWNER;
				used_slots = 0;
			end
			default: begin
				r.owner_entity = owner_copy[slot];
				r.occupied     = held_slots[slot];
			end
		endcase
		r.used_count = 7'(used_slots);
		return r;
	endfunction

	// random owned slot, or any slot while the table is empty
	function automatic logic [5:0] pick_owned_slot();
		int start;
		start = $urandom_range(TABLE_SLOTS - 1);
		for (int i = 0; i < TABLE_SLOTS; i++)
			if (held_slots[(start + i) % TABLE_SLOTS])
				return 6'((start + i) % TABLE_SLOTS);
		return 6'(start);
	endfunction

	// mostly random entities, now and then zero, the free marker or its neighbour
	function automatic logic [15:0] pick_entity();
		case ($urandom_range(19))
			0:       return 16'h0000;
			1:       return FREE_OWNER;
			2:       return 16'hFFFE;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// one request transaction; valid is left high for a following request
	task automatic send_request(input logic [2:0] act, input logic [5:0] slot,
			input logic [15:0] ent);
		while (!calm && $urandom_range(99) < 9) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, ent, slot, act};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_results.push_back(predict_alloc(act, slot, ent));
	endtask

	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// extremes of the fields, every action and the documented corner cases
	task automatic test_directed_ops();
		send_request(soa_pkg::ACT_READ,   6'd0,  16'h0000);	// read of a free slot
		send_request(soa_pkg::ACT_DELETE, 6'd5,  16'h0000);	// delete of a free slot
		send_request(soa_pkg::ACT_SET,    6'd63, 16'h1234);	// relabel of a free slot
		send_request(soa_pkg::ACT_ADD,    6'd63, 16'h0000);
		send_request(soa_pkg::ACT_ADD,    6'd0,  FREE_OWNER);	// free marker stored as owner
		send_request(soa_pkg::ACT_ADD,    6'd17, 16'hFFFE);
		send_request(soa_pkg::ACT_READ,   6'd1,  16'h0000);
		send_request(soa_pkg::ACT_SET,    6'd1,  16'h5555);
		send_request(soa_pkg::ACT_SET,    6'd0,  16'hAAAA);
		send_request(soa_pkg::ACT_DELETE, 6'd1,  16'hFFFF);
		send_request(soa_pkg::ACT_ADD,    6'd42, 16'h1234);	// first fit reuses the hole
		send_request(ACT_SPARE_5,         6'd0,  16'hFFFF);
		send_request(ACT_SPARE_6,         6'd2,  16'h0000);
		send_request(ACT_SPARE_7,         6'd63, 16'hFFFF);
		send_request(soa_pkg::ACT_DELETE, 6'd1,  16'h0000);
		send_request(soa_pkg::ACT_DELETE, 6'd1,  16'h0000);	// second delete finds it free
		send_request(soa_pkg::ACT_CLEAR,  6'd63, 16'hFFFF);
		send_request(soa_pkg::ACT_READ,   6'd0,  16'h0000);
		send_request(soa_pkg::ACT_READ,   6'd2,  16'h0000);
		send_request(soa_pkg::ACT_ADD,    6'd0,  16'h8001);
		// sender holds off until everything outstanding has come back
		wait_for_drain();
	endtask

	// fill to capacity with no idling, then exercise the full table
	task automatic test_fill_and_full();
		calm = 1'b1;
		while (used_slots < TABLE_SLOTS)
			send_request(soa_pkg::ACT_ADD, 6'($urandom), pick_entity());
		repeat (3)
			send_request(soa_pkg::ACT_ADD, 6'($urandom), pick_entity());
		send_request(soa_pkg::ACT_READ,   6'd63, 16'h0000);
		send_request(soa_pkg::ACT_SET,    pick_owned_slot(), pick_entity());
		send_request(soa_pkg::ACT_DELETE, 6'd37, 16'h0000);
		send_request(soa_pkg::ACT_ADD,    6'd0,  pick_entity());
		send_request(soa_pkg::ACT_DELETE, 6'd0,  16'h0000);
		send_request(soa_pkg::ACT_DELETE, pick_owned_slot(), 16'h0000);
		send_request(soa_pkg::ACT_ADD,    6'd0,  pick_entity());
		send_request(soa_pkg::ACT_ADD,    6'd0,  pick_entity());
		send_request(soa_pkg::ACT_CLEAR,  6'($urandom), 16'($urandom));
		send_request(soa_pkg::ACT_ADD,    6'($urandom), pick_entity());
		calm = 1'b0;
	endtask

	// phases with different add pressure so the fill level sweeps up and down
	task automatic test_random_traffic();
		int add_weights [4] = '{20, 45, 70, 90};
		int add_w;
		int roll;
		logic [2:0] act;
		logic [5:0] slot;
		for (int phase = 0; phase < 16; phase++) begin
			add_w = add_weights[phase % 4];
			for (int n = 0; n < 97; n++) begin
				roll = $urandom_range(99);
				if (roll < 1)
					act = soa_pkg::ACT_CLEAR;
				else if (roll < 1 + add_w)
					act = soa_pkg::ACT_ADD;
				else begin
					case ($urandom_range(9))
						0, 1, 2, 3: act = soa_pkg::ACT_DELETE;
						4, 5, 6:    act = soa_pkg::ACT_SET;
						7, 8:       act = soa_pkg::ACT_READ;
						default:    act = 3'($urandom_range(ACT_SPARE_5, ACT_SPARE_7));
					endcase
				end
				slot = ($urandom_range(3) != 0) ? pick_owned_slot() : 6'($urandom);
				send_request(act, slot, pick_entity());
			end
		end
	endtask

	// receiver stalls at random except while calm
	always @(posedge clk)
		m_axis_tready <= calm || ($urandom_range(99) >= 9);

	always @(posedge clk) begin : check_responses
		alloc_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0)
				report_mismatch($sformatf("response %h with nothing outstanding",
					m_axis_tdata));
			else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[5:0] !== want.slot_index)
					report_mismatch($sformatf("slot_index %0d, want %0d",
						m_axis_tdata[5:0], want.slot_index));
				if (m_axis_tdata[21:6] !== want.owner_entity)
					report_mismatch($sformatf("owner_entity %h, want %h",
						m_axis_tdata[21:6], want.owner_entity));
				if (m_axis_tdata[22] !== want.occupied)
					report_mismatch($sformatf("occupied %b, want %b",
						m_axis_tdata[22], want.occupied));
				if (m_axis_tdata[24:23] !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						m_axis_tdata[24:23], want.status));
				if (m_axis_tdata[31:25] !== want.used_count)
					report_mismatch($sformatf("used_count %0d, want %0d",
						m_axis_tdata[31:25], want.used_count));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("slot_owner_allocator_top test failed");
			$finish;
		end
	end

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_fill_and_full();
		test_random_traffic();
		wait_for_drain();
		repeat (10)
			@(posedge clk);
		if (mismatches == 0)
			$display("slot_owner_allocator_top test passed");
		else
			$display("slot_owner_allocator_top test failed");
		$finish;
	end

endmodule
